### src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer and its channels.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFFS_W = 11;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [BYTE_W-1:0] RESET_ATTR   = 8'h07;

  typedef enum logic [1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_SET   = 2'd2,
    REQ_READ  = 2'd3
  } tcw_req_type_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CLEAR,
    ST_COPY,
    ST_BLANK,
    ST_RDWAIT,
    ST_FINISH
  } tcw_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] attr;
    logic [BYTE_W-1:0] ch;
  } tcw_cell_t;

  typedef struct packed {
    tcw_req_type_t     req_type;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] cell_attribute;
    logic [COL_W-1:0]  col_in;
    logic [ROW_W-1:0]  row_in;
  } tcw_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col_out;
    logic [ROW_W-1:0]  cursor_row_out;
    logic [OFFS_W-1:0] cursor_offset;
    logic [BYTE_W-1:0] read_char;
    logic [BYTE_W-1:0] read_attribute;
    logic              accepted;
    logic              scrolled;
  } tcw_rsp_t;

endpackage

### src/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if
// Valid/ready channels carrying console requests and responses.
// ----------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
  logic     valid;
  logic     ready;
  tcw_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcw_rsp_if import tcw_pkg::*; ();
  logic     valid;
  logic     ready;
  tcw_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text-mode console: a ROWS x COLS store of character/attribute cells and a
// cursor, driven by put char, clear, set cursor and read cell requests.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     payload
//  req       in         valid/ready   tcw_req_t (one request)
//  rsp       out        valid/ready   tcw_rsp_t (one response per request)
//  cfg       in         cfg_we        cfg_data: scroll fill attribute
//
//  Set cursor and a put char that does not scroll go straight to ST_FINISH;
//  an on-grid read cell waits in ST_RDWAIT for the registered store data.
//  Clear and a scrolling put char pass over the whole store through its
//  single write port. While ST_INIT blanks the store after rst, req.ready
//  stays low. A held response admits the next request, stalls the one after.
// ----------------------------------------------------------------------------
module text_console_writer_unit import tcw_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic              clk,
  input  logic              rst,
  tcw_req_if.sink           req,
  tcw_rsp_if.source         rsp,
  input  logic              cfg_we,
  input  logic [BYTE_W-1:0] cfg_data
);

  localparam int DEPTH     = ROWS * COLS;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int FULL_W    = ROW_W + COL_W + 1;
  localparam int LAST_COPY = (ROWS - 1) * COLS;

  tcw_state_t state, state_next;

  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [CW-1:0]     cnt;
  logic [BYTE_W-1:0] scroll_attr;
  logic [BYTE_W-1:0] fill_attr;
  logic              res_acc;
  logic              res_scr;
  logic [BYTE_W-1:0] res_ch;
  logic [BYTE_W-1:0] res_attr;
  logic              rsp_valid;
  tcw_rsp_t          rsp_data;

  tcw_cell_t         store [DEPTH];
  tcw_cell_t         mem_rdata;
  tcw_cell_t         mem_wdata;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;

  logic              in_ready;
  logic              in_fire;
  logic              out_free;
  logic              in_inside;
  logic              row_end;
  logic              bottom_row;
  logic [FULL_W-1:0] cur_full;
  logic [FULL_W-1:0] in_full;

  assign in_fire  = req.valid && in_ready;
  assign out_free = !rsp_valid || rsp.ready;

  assign cur_full = FULL_W'(cursor_row) * FULL_W'(COLS) + FULL_W'(cursor_col);
  assign in_full  = FULL_W'(req.data.row_in) * FULL_W'(COLS) + FULL_W'(req.data.col_in);

  assign in_inside = ({1'b0, req.data.col_in} < (COL_W + 1)'(COLS)) &&
                     ({1'b0, req.data.row_in} < (ROW_W + 1)'(ROWS));
  assign row_end    = (req.data.char_code == NEWLINE_CODE) ||
                      (cursor_col == COL_W'(COLS - 1));
  assign bottom_row = (cursor_row == ROW_W'(ROWS - 1));

  // Cell store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= store[mem_raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (req.data.req_type)
            REQ_PUT:   state_next = (row_end && bottom_row) ? ST_COPY : ST_FINISH;
            REQ_CLEAR: state_next = ST_CLEAR;
            REQ_SET:   state_next = ST_FINISH;
            REQ_READ:  state_next = in_inside ? ST_RDWAIT : ST_FINISH;
            default:   state_next = ST_FINISH;
          endcase
        end
      end
      ST_INIT:   if (cnt == CW'(DEPTH - 1)) state_next = ST_IDLE;
      ST_CLEAR:  if (cnt == CW'(DEPTH - 1)) state_next = ST_FINISH;
      ST_COPY:   if (cnt == CW'(LAST_COPY)) state_next = ST_BLANK;
      ST_BLANK:  if (cnt == CW'(DEPTH - 1)) state_next = ST_FINISH;
      ST_RDWAIT: state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cnt[AW-1:0];
    mem_raddr = in_full[AW-1:0];
    mem_wdata = '{attr: RESET_ATTR, ch: SPACE_CODE};
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && req.data.req_type == REQ_PUT &&
            req.data.char_code != NEWLINE_CODE) begin
          mem_we    = 1'b1;
          mem_waddr = cur_full[AW-1:0];
          mem_wdata = '{attr: req.data.cell_attribute, ch: req.data.char_code};
        end
        if (in_fire && req.data.req_type == REQ_READ && in_inside) begin
          mem_re = 1'b1;
        end
      end
      ST_INIT: begin
        mem_we = 1'b1;
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '{attr: fill_attr, ch: SPACE_CODE};
      end
      ST_COPY: begin
        // read one row ahead, write back what the previous cycle fetched
        mem_re    = (cnt != CW'(LAST_COPY));
        mem_raddr = AW'(cnt + CW'(COLS));
        mem_we    = (cnt != '0);
        mem_waddr = AW'(cnt - CW'(1));
        mem_wdata = mem_rdata;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = '{attr: scroll_attr, ch: SPACE_CODE};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_INIT;
      cnt         <= '0;
      cursor_col  <= '0;
      cursor_row  <= '0;
      scroll_attr <= RESET_ATTR;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        scroll_attr <= cfg_data;
      end

      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_fire) begin
            // drop set cursor and read cell requests that fall off the grid
            res_acc  <= !(((req.data.req_type == REQ_SET) ||
                           (req.data.req_type == REQ_READ)) && !in_inside);
            res_scr  <= (req.data.req_type == REQ_PUT) && row_end && bottom_row;
            res_ch   <= '0;
            res_attr <= '0;
            case (req.data.req_type)
              REQ_PUT: begin
                if (row_end) begin
                  cursor_col <= '0;
                  if (!bottom_row) begin
                    cursor_row <= cursor_row + ROW_W'(1);
                  end
                end else begin
                  cursor_col <= cursor_col + COL_W'(1);
                end
              end
              REQ_CLEAR: begin
                cursor_col <= '0;
                cursor_row <= '0;
                fill_attr  <= req.data.cell_attribute;
              end
              REQ_SET: begin
                if (in_inside) begin
                  cursor_col <= req.data.col_in;
                  cursor_row <= req.data.row_in;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_INIT, ST_CLEAR, ST_BLANK: begin
          cnt <= cnt + CW'(1);
        end
        ST_COPY: begin
          // hold at the first bottom-row cell so the blank pass starts there
          if (cnt != CW'(LAST_COPY)) begin
            cnt <= cnt + CW'(1);
          end
        end
        ST_RDWAIT: begin
          res_ch   <= mem_rdata.ch;
          res_attr <= mem_rdata.attr;
        end
        default: begin
          cnt <= cnt;
        end
      endcase

      if (state == ST_FINISH && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload register
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      rsp_data.cursor_col_out <= cursor_col;
      rsp_data.cursor_row_out <= cursor_row;
      rsp_data.cursor_offset  <= cur_full[OFFS_W-1:0];
      rsp_data.read_char      <= res_ch;
      rsp_data.read_attribute <= res_attr;
      rsp_data.accepted       <= res_acc;
      rsp_data.scrolled       <= res_scr;
    end
  end

  assign req.ready = in_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  a_cursor_in_grid: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cursor_col} < (COL_W + 1)'(COLS)) && ({1'b0, cursor_row} < (ROW_W + 1)'(ROWS)))
    else $error("cursor left the grid");

  a_read_waits: assert property (@(posedge clk) disable iff (rst)
    (in_fire && req.data.req_type == REQ_READ && in_inside) |=> state == ST_RDWAIT)
    else $error("read request did not wait for store data");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.scrolled) |-> rsp_data.cursor_row_out == ROW_W'(ROWS - 1))
    else $error("scroll reported off the bottom row");

  a_copy_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY && mem_we && mem_re) |-> mem_waddr != mem_raddr)
    else $error("scroll copy read and write hit the same cell");

endmodule
